[hw/rtl/chunk_reassembly_tracker_top_assert.svh]
// Assertion macros for the chunk reassembly tracker.
// Used by crt_datapath under hw/rtl; needs nothing else.
`ifndef CHUNK_REASSEMBLY_TRACKER_TOP_ASSERT_SVH
`define CHUNK_REASSEMBLY_TRACKER_TOP_ASSERT_SVH
// Same-cycle implication, disabled in reset.
`define CRT_ASSERT_NOW(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define CRT_ASSERT_NEXT(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("assertion failed");
`endif

[hw/rtl/crt_pkg.sv]
// Package for the chunk reassembly tracker: types, codes and defaults.
// No dependencies.
`default_nettype none
package crt_pkg;
   localparam int TABLE_SLOTS_DEF  = 8;
   localparam int MAX_CHUNKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 32;
   localparam int TOTAL_W = 7;

   typedef enum logic [3:0] {
      ST_ACCEPTED   = 4'd0,
      ST_COMPLETE   = 4'd1,
      ST_EMPTY      = 4'd2,
      ST_SHORT      = 4'd3,
      ST_SIZE       = 4'd4,
      ST_HEADER     = 4'd5,
      ST_BAD_INDEX  = 4'd6,
      ST_DUPLICATE  = 4'd7,
      ST_TABLE_FULL = 4'd8,
      ST_TOO_MANY   = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } stat_type;
endpackage
`default_nettype wire

[hw/rtl/crt_ctrl.sv]
// Controller state machine for the chunk reassembly tracker.
// Depends on crt_pkg.
`default_nettype none
module crt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  crt_pkg::stat_type      stat,
   output crt_pkg::cmd_type       cmd
);
   crt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= crt_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         crt_pkg::S_IDLE: begin
            // take nothing while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = crt_pkg::S_CHECK;
            end
         end
         crt_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = crt_pkg::S_FINISH;
         end
         crt_pkg::S_FINISH: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = crt_pkg::S_IDLE;
            end
         end
         default: state_in = crt_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[hw/rtl/crt_datapath.sv]
// Datapath for the chunk reassembly tracker: slot table, checks, delay, totals.
// Depends on crt_pkg and chunk_reassembly_tracker_top_assert.svh.
`default_nettype none
`include "chunk_reassembly_tracker_top_assert.svh"
module crt_datapath #(
   parameter int TABLE_SLOTS  = crt_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_CHUNKS   = crt_pkg::MAX_CHUNKS_DEF,
   parameter int HEADER_BYTES = crt_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  crt_pkg::cmd_type         cmd,
   output crt_pkg::stat_type        stat,
   input  wire logic                csr_valid,
   input  wire logic [23:0]         csr_slo_limit_ms,
   input  wire logic [31:0]         req_file_sequence,
   input  wire logic [31:0]         req_file_size,
   input  wire logic [15:0]         req_total_chunks,
   input  wire logic [15:0]         req_chunk_number,
   input  wire logic [15:0]         req_declared_length,
   input  wire logic [15:0]         req_payload_length,
   input  wire logic [47:0]         req_sent_at_ms,
   input  wire logic [47:0]         req_arrived_at_ms,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output crt_pkg::status_type      rsp_status,
   output logic [31:0]              rsp_file_bytes_received,
   output logic [47:0]              rsp_delivery_delay_ms,
   output logic                     rsp_slo_met,
   output logic [31:0]              rsp_files_total,
   output logic [31:0]              rsp_slo_met_total,
   output logic [47:0]              rsp_bytes_total
);
   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int MAP_W  = MAX_CHUNKS;
   localparam int TW     = crt_pkg::TOTAL_W;

   // latched transaction
   logic [31:0] seq_ff, fsize_ff;
   logic [15:0] total_ff, idx_ff, decl_ff, plen_ff;
   logic [47:0] sent_ff, arr_ff;

   logic [23:0] slo_ff;
   logic        tb_set_ff;
   logic [47:0] first_ff, start_ff;

   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [31:0]   t_seq_ff   [TABLE_SLOTS];
   logic [31:0]   t_fsize_ff [TABLE_SLOTS];
   logic [TW-1:0] t_total_ff [TABLE_SLOTS];
   logic [TW-1:0] t_seen_ff  [TABLE_SLOTS];
   logic [31:0]   t_sum_ff   [TABLE_SLOTS];
   logic [47:0]   t_late_ff  [TABLE_SLOTS];
   logic [MAP_W-1:0] t_map_ff [TABLE_SLOTS];

   // check-stage results
   crt_pkg::status_type st_ff, st_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic wr_ff, wr_in, drop_ff, drop_in;
   logic [TW-1:0] n_total_ff, n_total_in, n_seen_ff, n_seen_in;
   logic [31:0] n_sum_ff, n_sum_in;
   logic [47:0] n_late_ff, n_late_in;
   logic [MAP_W-1:0] n_map_ff, n_map_in;

   logic [31:0] cnt_ff, met_cnt_ff;
   logic [47:0] bytes_ff;
   logic        out_v_ff;

   // lookup
   logic hit_any, free_any;
   logic [SLOT_W-1:0] hit_idx, free_idx;
   logic [15:0] body_bytes;
   logic [TW-1:0] b_total, b_seen;
   logic [31:0] b_sum;
   logic [47:0] b_late;
   logic [MAP_W-1:0] b_map;
   logic dup_bit;

   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         if (valid_ff[s]) begin
            if (!hit_any && t_seq_ff[s] == seq_ff) begin
               hit_any = 1'b1;
               hit_idx = SLOT_W'(s);
            end
         end else if (!free_any) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      body_bytes = plen_ff - 16'(HEADER_BYTES);
      st_in    = crt_pkg::ST_ACCEPTED;
      slot_in  = hit_any ? hit_idx : free_idx;
      wr_in    = 1'b0;
      drop_in  = 1'b0;
      b_total  = hit_any ? t_total_ff[hit_idx] : total_ff[TW-1:0];
      b_seen   = hit_any ? t_seen_ff[hit_idx]  : '0;
      b_sum    = hit_any ? t_sum_ff[hit_idx]   : '0;
      b_late   = hit_any ? t_late_ff[hit_idx]  : '0;
      b_map    = hit_any ? t_map_ff[hit_idx]   : '0;
      dup_bit  = |((b_map >> idx_ff[5:0]) & MAP_W'(1));
      n_total_in = b_total;
      n_seen_in  = b_seen + TW'(1);
      n_sum_in   = b_sum + 32'(body_bytes);
      n_late_in  = (sent_ff > b_late) ? sent_ff : b_late;
      n_map_in   = b_map | (MAP_W'(1) << idx_ff[5:0]);
      if (plen_ff == 16'd0) st_in = crt_pkg::ST_EMPTY;
      else if (plen_ff < 16'(HEADER_BYTES)) st_in = crt_pkg::ST_SHORT;
      else if (body_bytes != decl_ff) st_in = crt_pkg::ST_SIZE;
      else if (hit_any) begin
         if (t_fsize_ff[hit_idx] != fsize_ff ||
             16'(t_total_ff[hit_idx]) != total_ff) begin
            st_in   = crt_pkg::ST_HEADER;
            drop_in = 1'b1;
         end else if (idx_ff >= 16'(b_total)) st_in = crt_pkg::ST_BAD_INDEX;
         else if (dup_bit) st_in = crt_pkg::ST_DUPLICATE;
         else wr_in = 1'b1;
      end else begin
         if (total_ff > 16'(MAX_CHUNKS)) st_in = crt_pkg::ST_TOO_MANY;
         else if (idx_ff >= total_ff) st_in = crt_pkg::ST_BAD_INDEX;
         else if (!free_any) st_in = crt_pkg::ST_TABLE_FULL;
         else wr_in = 1'b1;
      end
      if (wr_in && n_seen_in >= n_total_in) st_in = crt_pkg::ST_COMPLETE;
   end

   // delay of the completing file
   logic [47:0] rel;
   logic [48:0] end_t;
   logic [47:0] delay;
   logic        met;
   logic        done;
   always_comb begin
      rel   = (n_late_ff >= first_ff) ? n_late_ff - first_ff : '0;
      end_t = {1'b0, start_ff} + {1'b0, rel};
      if (end_t > {1'b0, sent_ff}) begin
         if (end_t - {1'b0, sent_ff} > 49'h0_FFFF_FFFF_FFFF) delay = '1;
         else delay = 48'(end_t - {1'b0, sent_ff});
      end else delay = '0;
      met  = (slo_ff == 24'd0) || (delay <= 48'(slo_ff));
      done = (st_ff == crt_pkg::ST_COMPLETE);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff   <= req_file_sequence;
         fsize_ff <= req_file_size;
         total_ff <= req_total_chunks;
         idx_ff   <= req_chunk_number;
         decl_ff  <= req_declared_length;
         plen_ff  <= req_payload_length;
         sent_ff  <= req_sent_at_ms;
         arr_ff   <= req_arrived_at_ms;
      end
      if (cmd.check) begin
         st_ff      <= st_in;
         slot_ff    <= slot_in;
         wr_ff      <= wr_in;
         drop_ff    <= drop_in;
         n_total_ff <= n_total_in;
         n_seen_ff  <= n_seen_in;
         n_sum_ff   <= n_sum_in;
         n_late_ff  <= n_late_in;
         n_map_ff   <= n_map_in;
      end
      if (cmd.finish && wr_ff) begin
         t_seq_ff[slot_ff]   <= seq_ff;
         t_fsize_ff[slot_ff] <= fsize_ff;
         t_total_ff[slot_ff] <= n_total_ff;
         t_seen_ff[slot_ff]  <= n_seen_ff;
         t_sum_ff[slot_ff]   <= n_sum_ff;
         t_late_ff[slot_ff]  <= n_late_ff;
         t_map_ff[slot_ff]   <= n_map_ff;
      end
      if (cmd.finish) begin
         rsp_status              <= st_ff;
         rsp_file_bytes_received <= done ? n_sum_ff : '0;
         rsp_delivery_delay_ms   <= done ? delay : '0;
         rsp_slo_met             <= done & met;
         rsp_files_total         <= cnt_ff + (done ? 32'd1 : 32'd0);
         rsp_slo_met_total       <= met_cnt_ff + ((done && met) ? 32'd1 : 32'd0);
         rsp_bytes_total         <= bytes_ff + (done ? 48'(n_sum_ff) : 48'd0);
      end
      if (reset) begin
         slo_ff     <= '0;
         tb_set_ff  <= 1'b0;
         first_ff   <= '0;
         start_ff   <= '0;
         valid_ff   <= '0;
         cnt_ff     <= '0;
         met_cnt_ff <= '0;
         bytes_ff   <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         if (csr_valid) slo_ff <= csr_slo_limit_ms;
         // latch the sender time base on the first size-clean payload
         if (cmd.check && !tb_set_ff && st_in != crt_pkg::ST_EMPTY &&
             st_in != crt_pkg::ST_SHORT && st_in != crt_pkg::ST_SIZE) begin
            tb_set_ff <= 1'b1;
            first_ff  <= sent_ff;
            start_ff  <= arr_ff;
         end
         if (cmd.finish) begin
            if (drop_ff) valid_ff[slot_ff] <= 1'b0;
            else if (wr_ff) valid_ff[slot_ff] <= !done;
            if (done) begin
               cnt_ff   <= cnt_ff + 32'd1;
               bytes_ff <= bytes_ff + 48'(n_sum_ff);
               if (met) met_cnt_ff <= met_cnt_ff + 32'd1;
            end
         end
         if (cmd.finish) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign stat.out_busy = out_v_ff && !rsp_ready;

   `CRT_ASSERT_NEXT(a_finish_shows, clock, reset, cmd.finish, rsp_valid)
   `CRT_ASSERT_NOW(a_zero_unless_done, clock, reset,
      rsp_valid && rsp_status != crt_pkg::ST_COMPLETE, rsp_delivery_delay_ms == 48'd0)
   `CRT_ASSERT_NEXT(a_count_step, clock, reset, cmd.finish && done,
      cnt_ff == $past(cnt_ff) + 32'd1)
endmodule
`default_nettype wire

[hw/rtl/chunk_reassembly_tracker_top.sv]
// Top level of the chunk reassembly tracker: controller plus datapath.
// Depends on crt_pkg, crt_ctrl and crt_datapath.
//
// Takes one chunk-header transaction at a time and answers each with exactly
// one result transaction. The result is registered after the header is
// accepted (table lookup and check, then write back with delay math) and can
// be taken by the consumer on the cycle after that; the next header can be
// accepted in that same cycle, so the block takes a new header only after the
// last result is registered, as set by the controller's capture/check/finish
// sequence. A result held by a stalled consumer stalls the finish step only.
// The file table has TABLE_SLOTS entries in flops; valid bits clear at reset,
// no clearing pass. Neither channel is ready while reset is held. The SLO
// limit register is written through csr_valid/csr_ready (ready whenever reset
// is low); write it only while idle.
`default_nettype none
module chunk_reassembly_tracker_top #(
   parameter int TABLE_SLOTS  = crt_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_CHUNKS   = crt_pkg::MAX_CHUNKS_DEF,
   parameter int HEADER_BYTES = crt_pkg::HEADER_BYTES_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [23:0]    csr_slo_limit_ms,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [31:0]    req_file_sequence,
   input  wire logic [31:0]    req_file_size,
   input  wire logic [15:0]    req_total_chunks,
   input  wire logic [15:0]    req_chunk_number,
   input  wire logic [15:0]    req_declared_length,
   input  wire logic [15:0]    req_payload_length,
   input  wire logic [47:0]    req_sent_at_ms,
   input  wire logic [47:0]    req_arrived_at_ms,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output crt_pkg::status_type rsp_status,
   output logic [31:0]         rsp_file_bytes_received,
   output logic [47:0]         rsp_delivery_delay_ms,
   output logic                rsp_slo_met,
   output logic [31:0]         rsp_files_total,
   output logic [31:0]         rsp_slo_met_total,
   output logic [47:0]         rsp_bytes_total
);
   crt_pkg::cmd_type  cmd;
   crt_pkg::stat_type stat;

   // register write never stalls outside reset
   assign csr_ready = !reset;

   crt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   crt_datapath #(
      .TABLE_SLOTS  (TABLE_SLOTS),
      .MAX_CHUNKS   (MAX_CHUNKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .csr_valid               (csr_valid),
      .csr_slo_limit_ms        (csr_slo_limit_ms),
      .req_file_sequence       (req_file_sequence),
      .req_file_size           (req_file_size),
      .req_total_chunks        (req_total_chunks),
      .req_chunk_number        (req_chunk_number),
      .req_declared_length     (req_declared_length),
      .req_payload_length      (req_payload_length),
      .req_sent_at_ms          (req_sent_at_ms),
      .req_arrived_at_ms       (req_arrived_at_ms),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_file_bytes_received (rsp_file_bytes_received),
      .rsp_delivery_delay_ms   (rsp_delivery_delay_ms),
      .rsp_slo_met             (rsp_slo_met),
      .rsp_files_total         (rsp_files_total),
      .rsp_slo_met_total       (rsp_slo_met_total),
      .rsp_bytes_total         (rsp_bytes_total)
   );
endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for chunk_reassembly_tracker_top: drives chunk headers and
// SLO writes, predicts every result in a scoreboard class and checks each response.
// Depends on crt_pkg and the RTL of the block only.
`default_nettype none
module testbench;
   localparam int SLOTS = crt_pkg::TABLE_SLOTS_DEF;
   localparam int CHUNK_MAX = crt_pkg::MAX_CHUNKS_DEF;
   localparam int HDR = crt_pkg::HEADER_BYTES_DEF;
   localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [31:0] sequence_id;
      logic [31:0] size;
      logic [15:0] total;
      logic [15:0] index;
      logic [15:0] declared;
      logic [15:0] plen;
      logic [47:0] sent;
      logic [47:0] arrived;
   } chunk_type;

   typedef struct {
      crt_pkg::status_type status;
      logic [31:0] fbytes;
      logic [47:0] delay;
      logic        met;
      logic [31:0] files;
      logic [31:0] met_files;
      logic [47:0] bytes;
   } verdict_type;

   // Reassembly predictor plus the queue of results still owed by the block.
   class reassembly_scoreboard;
      logic [23:0] slo_limit;
      bit          base_set;
      logic [47:0] first_send, start_time;
      bit          valid_q[SLOTS];
      logic [31:0] seq_q[SLOTS], size_q[SLOTS], sum_q[SLOTS];
      logic [15:0] total_q[SLOTS];
      logic [6:0]  seen_q[SLOTS];
      logic [47:0] latest_q[SLOTS];
      logic [63:0] map_q[SLOTS];
      logic [31:0] done_count, met_count;
      logic [47:0] done_bytes;
      verdict_type pending[$];
      int          errors;

      function new();
         slo_limit = 0; base_set = 0; first_send = 0; start_time = 0;
         done_count = 0; met_count = 0; done_bytes = 0; errors = 0;
         foreach (valid_q[i]) valid_q[i] = 0;
      endfunction

      function void owe(crt_pkg::status_type st, logic [31:0] fb, logic [47:0] dl,
                        logic met);
         verdict_type v;
         v.status = st; v.fbytes = fb; v.delay = dl; v.met = met;
         v.files = done_count; v.met_files = met_count; v.bytes = done_bytes;
         pending = {pending, v};
      endfunction

      // Work out the result of one accepted chunk header and queue it.
      function void note_chunk(chunk_type c);
         int hit, slot_free;
         logic [15:0] body;
         logic [63:0] rel, stop, dl;
         logic met;
         hit = -1; slot_free = -1;
         if (c.plen == 0) begin owe(crt_pkg::ST_EMPTY, 0, 0, 0); return; end
         if (c.plen < HDR) begin owe(crt_pkg::ST_SHORT, 0, 0, 0); return; end
         body = c.plen - 16'(HDR);
         if (body != c.declared) begin owe(crt_pkg::ST_SIZE, 0, 0, 0); return; end
         if (!base_set) begin
            base_set = 1; first_send = c.sent; start_time = c.arrived;
         end
         for (int s = 0; s < SLOTS; s++) begin
            if (valid_q[s]) begin
               if (hit < 0 && seq_q[s] == c.sequence_id) hit = s;
            end else if (slot_free < 0) slot_free = s;
         end
         if (hit >= 0) begin
            if (size_q[hit] != c.size || total_q[hit] != c.total) begin
               valid_q[hit] = 0; owe(crt_pkg::ST_HEADER, 0, 0, 0); return;
            end
            if (c.index >= total_q[hit]) begin
               owe(crt_pkg::ST_BAD_INDEX, 0, 0, 0); return;
            end
            if (map_q[hit][c.index[5:0]]) begin
               owe(crt_pkg::ST_DUPLICATE, 0, 0, 0); return;
            end
         end else begin
            if (c.total > CHUNK_MAX) begin owe(crt_pkg::ST_TOO_MANY, 0, 0, 0); return; end
            if (c.index >= c.total) begin owe(crt_pkg::ST_BAD_INDEX, 0, 0, 0); return; end
            if (slot_free < 0) begin owe(crt_pkg::ST_TABLE_FULL, 0, 0, 0); return; end
            hit = slot_free;
            valid_q[hit] = 1; seq_q[hit] = c.sequence_id; size_q[hit] = c.size;
            total_q[hit] = c.total; seen_q[hit] = 0; sum_q[hit] = 0;
            latest_q[hit] = 0; map_q[hit] = 0;
         end
         map_q[hit][c.index[5:0]] = 1'b1;
         seen_q[hit] = seen_q[hit] + 7'd1;
         sum_q[hit] = sum_q[hit] + 32'(body);
         if (c.sent > latest_q[hit]) latest_q[hit] = c.sent;
         if (seen_q[hit] < total_q[hit]) begin owe(crt_pkg::ST_ACCEPTED, 0, 0, 0); return; end
         rel = (latest_q[hit] >= first_send) ? 64'(latest_q[hit] - first_send) : 64'd0;
         stop = 64'(start_time) + rel;
         dl = (stop > 64'(c.sent)) ? stop - 64'(c.sent) : 64'd0;
         if (dl > TIME_MAX) dl = TIME_MAX;
         met = (slo_limit == 0 || dl <= 64'(slo_limit));
         done_count = done_count + 1;
         if (met) met_count = met_count + 1;
         done_bytes = done_bytes + 48'(sum_q[hit]);
         valid_q[hit] = 0;
         owe(crt_pkg::ST_COMPLETE, sum_q[hit], dl[47:0], met);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      endtask

      // Compare one response with the oldest owed result.
      task check_result(verdict_type r);
         verdict_type w;
         if (pending.size() == 0) begin
            report("unexpected response, status", r.status, 0);
            return;
         end
         w = pending.pop_front();
         if (r.status !== w.status) report("status", r.status, w.status);
         if (r.fbytes !== w.fbytes) report("file bytes", r.fbytes, w.fbytes);
         if (r.delay !== w.delay) report("delay", r.delay, w.delay);
         if (r.met !== w.met) report("slo met", r.met, w.met);
         if (r.files !== w.files) report("files total", r.files, w.files);
         if (r.met_files !== w.met_files) report("met total", r.met_files, w.met_files);
         if (r.bytes !== w.bytes) report("bytes total", r.bytes, w.bytes);
      endtask
   endclass

   logic clock, reset;
   logic csr_valid, csr_ready;
   logic [23:0] csr_slo_limit_ms;
   logic req_valid, req_ready;
   chunk_type req;
   logic rsp_valid, rsp_ready;
   crt_pkg::status_type rsp_status;
   logic [31:0] rsp_file_bytes_received, rsp_files_total, rsp_slo_met_total;
   logic [47:0] rsp_delivery_delay_ms, rsp_bytes_total;
   logic rsp_slo_met;

   reassembly_scoreboard board = new();
   bit steady;   // set during the stretch with no idling on either side

   chunk_reassembly_tracker_top dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_slo_limit_ms(csr_slo_limit_ms),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_file_sequence(req.sequence_id), .req_file_size(req.size),
      .req_total_chunks(req.total), .req_chunk_number(req.index),
      .req_declared_length(req.declared), .req_payload_length(req.plen),
      .req_sent_at_ms(req.sent), .req_arrived_at_ms(req.arrived),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_file_bytes_received(rsp_file_bytes_received),
      .rsp_delivery_delay_ms(rsp_delivery_delay_ms), .rsp_slo_met(rsp_slo_met),
      .rsp_files_total(rsp_files_total), .rsp_slo_met_total(rsp_slo_met_total),
      .rsp_bytes_total(rsp_bytes_total)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Randomly stall the response side, except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 23);
   end

   // Sample both channels at the rising edge; check the result before noting the
   // new transaction since a result always belongs to an earlier header.
   always @(posedge clock) begin
      verdict_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status; got.fbytes = rsp_file_bytes_received;
            got.delay = rsp_delivery_delay_ms; got.met = rsp_slo_met;
            got.files = rsp_files_total; got.met_files = rsp_slo_met_total;
            got.bytes = rsp_bytes_total;
            board.check_result(got);
         end
         if (req_valid && req_ready) board.note_chunk(req);
         if (csr_valid && csr_ready) board.slo_limit = csr_slo_limit_ms;
      end
   end

   // Present one header, idling first at random; hold until accepted.
   task send_chunk(chunk_type c);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 23) begin
         req_valid = 0;
         @(negedge clock);
      end
      req = c;
      req_valid = 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drain owed results, then write the SLO limit while the block is idle.
   task write_slo(logic [23:0] limit);
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid = 0;
      while (board.pending.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (6) @(negedge clock);
      csr_slo_limit_ms = limit;
      csr_valid = 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function chunk_type make_chunk(logic [31:0] sq, logic [31:0] sz, logic [15:0] tot,
                                  logic [15:0] ix, logic [15:0] pl, logic [47:0] st,
                                  logic [47:0] ar);
      chunk_type c;
      c.sequence_id = sq; c.size = sz; c.total = tot; c.index = ix; c.plen = pl;
      c.declared = (pl >= HDR) ? pl - 16'(HDR) : 16'd0;
      c.sent = st; c.arrived = ar;
      return c;
   endfunction

   task run_directed();
      chunk_type c;
      c = make_chunk(1, 100, 1, 0, 0, 0, 0);                  send_chunk(c); // empty
      c = make_chunk(1, 100, 1, 0, 16'(HDR - 1), 0, 0);       send_chunk(c); // short
      c = make_chunk(1, 100, 1, 0, 100, 0, 0);
      c.declared = 10;                                        send_chunk(c); // size mismatch
      // single chunk file latches the time base and completes at once
      c = make_chunk(0, 0, 1, 0, 16'(HDR), 48'd1000, 48'd2000); send_chunk(c);
      c = make_chunk(2, 5, 16'(CHUNK_MAX + 1), 0, 40, 1010, 2010);
      send_chunk(c);                                                         // too many
      c = make_chunk(2, 5, 16'hFFFF, 0, 40, 1010, 2010);      send_chunk(c);
      c = make_chunk(3, 5, 4, 4, 40, 1010, 2010);             send_chunk(c); // bad index, new
      c = make_chunk(3, 5, 0, 0, 40, 1010, 2010);             send_chunk(c); // zero chunks
      c = make_chunk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 0, 16'hFFFF, 1200, 2300);
      send_chunk(c);
      send_chunk(c);                                                         // duplicate
      c.index = 3;                                            send_chunk(c); // bad index, known
      c.index = 1; c.sent = 48'd900;                          send_chunk(c);
      c.index = 2; c.sent = 48'hFFFF_FFFF_FFFF;               send_chunk(c); // completes
      c = make_chunk(5, 64, 2, 0, 48, 1100, 2100);            send_chunk(c);
      c.size = 65;                                            send_chunk(c); // header mismatch
      c.size = 64;                                            send_chunk(c); // fresh entry
      for (int i = 0; i < SLOTS - 1; i++) begin
         c = make_chunk(10 + i, 7, 2, 0, 33, 1000 + i, 0);    send_chunk(c);
      end
      c = make_chunk(99, 7, 1, 0, 33, 1000, 0);               send_chunk(c); // table full
      // complete every slot so the table starts the random part empty
      c = make_chunk(5, 64, 2, 1, 48, 1500, 0);               send_chunk(c);
      for (int i = 0; i < SLOTS - 1; i++) begin
         c = make_chunk(10 + i, 7, 2, 1, 16'(33 + i), 800, 0); send_chunk(c);
      end
   endtask

   // Pool of files in flight used to build well-formed chunk streams.
   logic [31:0] pool_seq[10], pool_size[10];
   logic [15:0] pool_total[10];
   logic [63:0] pool_sent[10];

   function void new_file(int p);
      pool_seq[p] = $urandom();
      pool_size[p] = $urandom();
      pool_total[p] = ($urandom_range(9) == 0) ? 16'($urandom_range(CHUNK_MAX, 1))
                                               : 16'($urandom_range(6, 1));
      pool_sent[p] = 0;
   endfunction

   task run_random(int count);
      chunk_type c;
      int p, roll, ix;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         p = $urandom_range(9);
         if (roll < 8) begin
            // noise: every field random
            c.sequence_id = $urandom(); c.size = $urandom();
            c.total = 16'($urandom()); c.index = 16'($urandom());
            c.plen = 16'($urandom()); c.declared = 16'($urandom());
            c.sent = 48'({$urandom(), $urandom()});
            c.arrived = 48'({$urandom(), $urandom()});
            if ($urandom_range(1)) c.declared = c.plen - 16'(HDR);
         end else begin
            ix = $urandom_range(pool_total[p] - 1);
            // favor chunks not yet sent so files actually complete
            if ($urandom_range(9) != 0)
               for (int k = 0; k < pool_total[p]; k++)
                  if (!pool_sent[p][k]) begin
                     ix = k;
                     if ($urandom_range(2) == 0) break;
                  end
            c = make_chunk(pool_seq[p], pool_size[p], pool_total[p], 16'(ix),
                           16'($urandom_range(2000, HDR)), 48'd1000 + $urandom_range(6000),
                           48'd2000 + $urandom_range(6000));
            if (roll < 12) begin
               c.size = c.size ^ (32'd1 << $urandom_range(31));  // header mismatch
               new_file(p);
            end else if (roll < 14) c.index = pool_total[p] + 16'($urandom_range(3));
            else begin
               pool_sent[p][ix] = 1'b1;
               if (pool_sent[p] == (64'(1) << pool_total[p]) - 1 ||
                   (pool_total[p] == CHUNK_MAX && &pool_sent[p]))
                  new_file(p);
            end
         end
         send_chunk(c);
      end
   endtask

   initial begin
      logic [23:0] limits[6];
      int guard;
      limits = '{24'd0, 24'hFFFFFF, 24'd1, 24'd0, 24'd0, 24'd2500};
      limits[3] = 24'($urandom_range(6000));
      limits[4] = 24'($urandom());
      reset = 1; steady = 0;
      csr_valid = 0; csr_slo_limit_ms = 0; req_valid = 0; rsp_ready = 0;
      req = make_chunk(0, 0, 0, 0, 0, 0, 0);
      for (int p = 0; p < 10; p++) new_file(p);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_slo(limits[ph]);
         steady = (ph == 2);
         if (ph == 0) run_directed();
         run_random(300);
      end
      @(negedge clock);
      req_valid = 0;
      steady = 0;
      guard = 0;
      while (board.pending.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      while (board.pending.size() != 0) begin
         board.report("missing response, status", 0, board.pending[0].status);
         void'(board.pending.pop_front());
      end
      if (board.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
